### src/dslr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_pkg: shared types and constants of the dual servo ramp
// Field widths, item kinds, queue status and front-end state encoding.
// ----------------------------------------------------------------------------
package dslr_pkg;

    localparam int ANGLE_W           = 8;
    localparam int STEPS_W           = 8;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Queue entry, lowest bit first:
    // kind, goal_a, goal_b, mag_a, mag_b, neg_a, neg_b
    function automatic int entry_width(int fraction_bits);
        return 1 + 2 * ANGLE_W + 2 * (ANGLE_W + fraction_bits) + 2;
    endfunction

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_WAIT = 3'b010,
        FS_DIV  = 3'b100
    } front_state_t;

endpackage

### src/dslr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_div: serial restoring divider
// One quotient bit per cycle; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module dslr_div #(
    parameter int DIVIDEND_W = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [DIVIDEND_W-1:0]            dividend,
    input  logic [dslr_pkg::STEPS_W-1:0]     divisor,
    output logic                             done,
    output logic [DIVIDEND_W-1:0]            quotient
);

    localparam int DV_W  = dslr_pkg::STEPS_W;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DV_W-1:0]       rem_reg, rem_next;
    logic [DV_W-1:0]       dvs_reg, dvs_next;
    logic [DV_W:0]         trial;
    logic [DV_W:0]         diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DV_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DV_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/dslr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_fifo: short command queue between front and back
// Register array with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module dslr_fifo #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = dslr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [DATA_W-1:0]       push_data,
    input  logic                    pop,
    output logic [DATA_W-1:0]       head_data,
    output dslr_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/dslr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_front: input side of the servo ramp
// Takes beats, queues ticks at once, turns moves into increments.
// ----------------------------------------------------------------------------
module dslr_front #(
    parameter int FRACTION_BITS = dslr_pkg::FRACTION_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [3*dslr_pkg::ANGLE_W-1:0]            s_tdata,
    input  logic                                      s_tuser,
    input  logic [dslr_pkg::ANGLE_W-1:0]              settled_a,
    input  logic [dslr_pkg::ANGLE_W-1:0]              settled_b,
    input  dslr_pkg::queue_status_t                   queue_status,
    output logic                                      push,
    output logic [dslr_pkg::entry_width(FRACTION_BITS)-1:0] push_data
);

    localparam int AW      = dslr_pkg::ANGLE_W;
    localparam int MAG_W   = AW + FRACTION_BITS;

    dslr_pkg::front_state_t state_reg, state_next;

    logic [AW-1:0]                  tgt_a_reg, tgt_a_next;
    logic [AW-1:0]                  tgt_b_reg, tgt_b_next;
    logic [dslr_pkg::STEPS_W-1:0]   steps_reg, steps_next;
    logic                           neg_a_reg, neg_a_next;
    logic                           neg_b_reg, neg_b_next;
    logic                           accept;
    logic                           div_start;
    logic [AW-1:0]                  dist_a, dist_b;
    logic [MAG_W-1:0]               quo_a, quo_b;
    logic                           done_a, done_b;
    logic [dslr_pkg::STEPS_W-1:0]   in_steps;

    assign s_tready = (state_reg == dslr_pkg::FS_IDLE) && !queue_status.full;
    assign accept   = s_tvalid && s_tready;
    assign in_steps = s_tdata[3*AW-1:2*AW];

    assign dist_a = (tgt_a_reg >= settled_a) ? tgt_a_reg - settled_a : settled_a - tgt_a_reg;
    assign dist_b = (tgt_b_reg >= settled_b) ? tgt_b_reg - settled_b : settled_b - tgt_b_reg;

    dslr_div #(
        .DIVIDEND_W (MAG_W)
    ) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dist_a, {FRACTION_BITS{1'b0}}}),
        .divisor  (steps_reg),
        .done     (done_a),
        .quotient (quo_a)
    );

    dslr_div #(
        .DIVIDEND_W (MAG_W)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dist_b, {FRACTION_BITS{1'b0}}}),
        .divisor  (steps_reg),
        .done     (done_b),
        .quotient (quo_b)
    );

    always_comb
    begin
        state_next = state_reg;
        tgt_a_next = tgt_a_reg;
        tgt_b_next = tgt_b_reg;
        steps_next = steps_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        div_start  = 1'b0;
        push       = 1'b0;
        push_data  = '0;
        unique case (state_reg)
            dslr_pkg::FS_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == dslr_pkg::KIND_TICK)
                    begin
                        push      = 1'b1;
                        push_data = {{(dslr_pkg::entry_width(FRACTION_BITS) - 1){1'b0}},
                                     dslr_pkg::KIND_TICK};
                    end
                    else
                    begin
                        tgt_a_next = s_tdata[AW-1:0];
                        tgt_b_next = s_tdata[2*AW-1:AW];
                        // zero steps runs as a single step
                        steps_next = (in_steps == '0) ? dslr_pkg::STEPS_W'(1) : in_steps;
                        state_next = dslr_pkg::FS_WAIT;
                    end
                end
            end
            dslr_pkg::FS_WAIT:
            begin
                // settled angles are final only once the back has drained the queue
                if (queue_status.empty)
                begin
                    div_start  = 1'b1;
                    neg_a_next = tgt_a_reg < settled_a;
                    neg_b_next = tgt_b_reg < settled_b;
                    state_next = dslr_pkg::FS_DIV;
                end
            end
            dslr_pkg::FS_DIV:
            begin
                if (done_a && done_b)
                begin
                    push       = 1'b1;
                    push_data  = {neg_b_reg, neg_a_reg, quo_b, quo_a,
                                  tgt_b_reg, tgt_a_reg, dslr_pkg::KIND_MOVE};
                    state_next = dslr_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = dslr_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dslr_pkg::FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_a_reg <= tgt_a_next;
        tgt_b_reg <= tgt_b_next;
        steps_reg <= steps_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
    end

endmodule

### src/dslr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslr_back: ramp execution side
// Applies queued moves and ticks to the positions, drives result beats.
// ----------------------------------------------------------------------------
module dslr_back #(
    parameter int FRACTION_BITS = dslr_pkg::FRACTION_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [dslr_pkg::entry_width(FRACTION_BITS)-1:0] head_data,
    input  dslr_pkg::queue_status_t                   queue_status,
    output logic                                      pop,
    output logic [dslr_pkg::ANGLE_W-1:0]              settled_a,
    output logic [dslr_pkg::ANGLE_W-1:0]              settled_b,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [2*dslr_pkg::ANGLE_W-1:0]            m_tdata,
    output logic                                      m_tuser
);

    localparam int AW     = dslr_pkg::ANGLE_W;
    localparam int MAG_W  = AW + FRACTION_BITS;
    localparam int GA_LSB = 1;
    localparam int GB_LSB = GA_LSB + AW;
    localparam int MA_LSB = GB_LSB + AW;
    localparam int MB_LSB = MA_LSB + MAG_W;
    localparam int NA_BIT = MB_LSB + MAG_W;
    localparam int NB_BIT = NA_BIT + 1;

    // returns {within one degree, new position}
    function automatic logic [MAG_W:0] advance(
        input logic [MAG_W-1:0] pos,
        input logic [MAG_W-1:0] mag,
        input logic             neg,
        input logic [AW-1:0]    goal
    );
        logic [MAG_W-1:0] gfix;
        logic [MAG_W-1:0] gap;
        logic [MAG_W-1:0] npos;
        logic [MAG_W-1:0] ndist;
        gfix = {goal, {FRACTION_BITS{1'b0}}};
        gap  = (pos >= gfix) ? pos - gfix : gfix - pos;
        if (gap >= mag)
        begin
            npos = neg ? pos - mag : pos + mag;
        end
        else
        begin
            npos = gfix;
        end
        ndist = (npos >= gfix) ? npos - gfix : gfix - npos;
        return {(ndist[MAG_W-1:FRACTION_BITS] == '0), npos};
    endfunction

    logic [MAG_W-1:0] pos_a_reg, pos_a_next;
    logic [MAG_W-1:0] pos_b_reg, pos_b_next;
    logic [MAG_W-1:0] mag_a_reg, mag_a_next;
    logic [MAG_W-1:0] mag_b_reg, mag_b_next;
    logic             neg_a_reg, neg_a_next;
    logic             neg_b_reg, neg_b_next;
    logic [AW-1:0]    goal_a_reg, goal_a_next;
    logic [AW-1:0]    goal_b_reg, goal_b_next;
    logic [AW-1:0]    settled_a_reg, settled_a_next;
    logic [AW-1:0]    settled_b_reg, settled_b_next;
    logic             out_valid_reg, out_valid_next;
    logic [2*AW-1:0]  out_data_reg, out_data_next;
    logic             out_done_reg, out_done_next;
    logic             out_free;
    logic             head_kind;
    logic [MAG_W:0]   adv_a, adv_b;
    logic             both_done;

    assign head_kind = head_data[0];
    assign out_free  = !out_valid_reg || m_tready;
    assign pop       = !queue_status.empty &&
                       ((head_kind == dslr_pkg::KIND_MOVE) || out_free);
    assign adv_a     = advance(pos_a_reg, mag_a_reg, neg_a_reg, goal_a_reg);
    assign adv_b     = advance(pos_b_reg, mag_b_reg, neg_b_reg, goal_b_reg);
    assign both_done = adv_a[MAG_W] && adv_b[MAG_W];

    always_comb
    begin
        pos_a_next     = pos_a_reg;
        pos_b_next     = pos_b_reg;
        mag_a_next     = mag_a_reg;
        mag_b_next     = mag_b_reg;
        neg_a_next     = neg_a_reg;
        neg_b_next     = neg_b_reg;
        goal_a_next    = goal_a_reg;
        goal_b_next    = goal_b_reg;
        settled_a_next = settled_a_reg;
        settled_b_next = settled_b_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_done_next  = out_done_reg;
        if (pop)
        begin
            if (head_kind == dslr_pkg::KIND_MOVE)
            begin
                // restart both channels from their settled angles
                goal_a_next = head_data[GA_LSB +: AW];
                goal_b_next = head_data[GB_LSB +: AW];
                mag_a_next  = head_data[MA_LSB +: MAG_W];
                mag_b_next  = head_data[MB_LSB +: MAG_W];
                neg_a_next  = head_data[NA_BIT];
                neg_b_next  = head_data[NB_BIT];
                pos_a_next  = {settled_a_reg, {FRACTION_BITS{1'b0}}};
                pos_b_next  = {settled_b_reg, {FRACTION_BITS{1'b0}}};
            end
            else
            begin
                pos_a_next     = adv_a[MAG_W-1:0];
                pos_b_next     = adv_b[MAG_W-1:0];
                out_valid_next = 1'b1;
                out_data_next  = {adv_b[MAG_W-1:FRACTION_BITS], adv_a[MAG_W-1:FRACTION_BITS]};
                out_done_next  = both_done;
                if (both_done)
                begin
                    settled_a_next = goal_a_reg;
                    settled_b_next = goal_b_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_a_reg     <= '0;
            pos_b_reg     <= '0;
            mag_a_reg     <= '0;
            mag_b_reg     <= '0;
            neg_a_reg     <= 1'b0;
            neg_b_reg     <= 1'b0;
            goal_a_reg    <= '0;
            goal_b_reg    <= '0;
            settled_a_reg <= '0;
            settled_b_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_a_reg     <= pos_a_next;
            pos_b_reg     <= pos_b_next;
            mag_a_reg     <= mag_a_next;
            mag_b_reg     <= mag_b_next;
            neg_a_reg     <= neg_a_next;
            neg_b_reg     <= neg_b_next;
            goal_a_reg    <= goal_a_next;
            goal_b_reg    <= goal_b_next;
            settled_a_reg <= settled_a_next;
            settled_b_reg <= settled_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
    end

    assign settled_a = settled_a_reg;
    assign settled_b = settled_b_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_done_reg;

endmodule

### src/dual_servo_linear_ramp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_servo_linear_ramp_unit: two-channel linear servo angle ramp
// Move beats set new targets and step counts; tick beats advance both
// channels and return the integer angles with a done flag.
// ----------------------------------------------------------------------------
// A move beat (tuser = 0) gives target angles for channels A and B and a
// step count (0 runs as 1); it returns nothing. Each channel gets a signed
// increment of (target - settled) * 2^FRACTION_BITS / steps, magnitude
// truncated. A tick beat (tuser = 1) adds the increments, snaps a channel
// onto its target once the remaining distance is below the increment's
// magnitude, and returns one beat with both truncated angles and done,
// which is high once both channels are within one degree; the targets then
// become the settled angles. Ticks are accepted one per cycle while no move
// is in progress and the QUEUE_DEPTH command queue is not full; each one
// passes through a queue entry and then the output register. A move holds
// the input while the queue drains, while the serial dividers of both
// channels compute the increments, and while the result is queued.
// ----------------------------------------------------------------------------
module dual_servo_linear_ramp_unit #(
    parameter int FRACTION_BITS = dslr_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = dslr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [3*dslr_pkg::ANGLE_W-1:0]     s_tdata,   // target_a, target_b, steps
    input  logic                               s_tuser,   // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*dslr_pkg::ANGLE_W-1:0]     m_tdata,   // angle_a, angle_b
    output logic                               m_tuser    // done_res
);

    localparam int ENTRY_W = dslr_pkg::entry_width(FRACTION_BITS);

    logic                          push;
    logic [ENTRY_W-1:0]            push_data;
    logic                          pop;
    logic [ENTRY_W-1:0]            head_data;
    dslr_pkg::queue_status_t       queue_status;
    logic [dslr_pkg::ANGLE_W-1:0]  settled_a;
    logic [dslr_pkg::ANGLE_W-1:0]  settled_b;

    // classifies beats and computes move increments
    dslr_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .settled_a    (settled_a),
        .settled_b    (settled_b),
        .queue_status (queue_status),
        .push         (push),
        .push_data    (push_data)
    );

    dslr_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (queue_status)
    );

    // holds positions and settled angles, drives the result beats
    dslr_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_data    (head_data),
        .queue_status (queue_status),
        .pop          (pop),
        .settled_a    (settled_a),
        .settled_b    (settled_b),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule
